// File: hw/rtl/drf_pkg.sv
// drf_pkg: types and constants shared by the request queue modules.
// Field widths, operation and status codes, stored entry layout and
// controller/datapath command and status bundles.
package drf_pkg;

    localparam int ID_W     = 64;
    localparam int TIER_W   = 2;
    localparam int SIZE_W   = 64;
    localparam int STAMP_W  = 64;
    localparam int NUM_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [ID_W-1:0]    id;
        logic [TIER_W-1:0]  tier;
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // latch the accepted request
        logic    scan_start;  // begin duplicate scan from head
        logic    scan_step;   // advance the duplicate scan by one entry
        logic    enq_write;   // append the request at tail
        logic    deq_read;    // read the head entry
        logic    deq_pop;     // take head entry into the result
        logic    clear;       // empty the queue
        logic    set_status;  // result without data
        status_t status;
        logic    out_load;    // move result to the output register
    } drf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic id_zero;
        logic empty;
        logic full;
        logic scan_done;
        logic hit;
        logic out_free;
    } drf_sts_t;

endpackage

// File: hw/rtl/drf_ram.sv
// drf_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module drf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/drf_datapath.sv
// drf_datapath: queue pointers, request counter, duplicate scan, result and
// output registers. Uses drf_pkg and one drf_ram holding the queued entries.
module drf_datapath
    import drf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  drf_cmd_t                   cmd,
    output drf_sts_t                   sts,
    input  logic [OP_W-1:0]            op,
    input  logic [ID_W-1:0]            req_id,
    input  logic [TIER_W-1:0]          tier,
    input  logic [SIZE_W-1:0]          alloc_size,
    input  logic [STAMP_W-1:0]         time_stamp,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [NUM_W-1:0]           request_number,
    output logic [ID_W-1:0]            out_req_id,
    output logic [TIER_W-1:0]          out_tier,
    output logic [SIZE_W-1:0]          out_alloc_size,
    output logic [STAMP_W-1:0]         out_time_stamp,
    output logic [$clog2(DEPTH+1)-1:0] entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
        return (s == IDX_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // request
    op_t                req_op_reg;
    entry_t             req_reg;

    // queue control
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [NUM_W-1:0]   counter_reg, counter_next;

    // duplicate scan
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               hit_reg, hit_next;

    // result and output
    status_t            res_status_reg;
    entry_t             res_reg;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    entry_t             out_reg;
    logic [CNT_W-1:0]   out_count_reg;

    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_data;
    entry_t             wr_data;
    entry_t             enq_res;

    assign rd_en   = cmd.deq_read | (cmd.scan_step & (left_reg != '0));
    assign rd_addr = cmd.deq_read ? head_reg : ptr_reg;

    always_comb
    begin
        wr_data        = req_reg;
        wr_data.number = counter_reg + 1'b1;
        // enqueue result carries only the new number
        enq_res        = '0;
        enq_res.number = wr_data.number;
    end

    drf_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (cmd.enq_write),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        counter_next   = counter_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;

        if (cmd.scan_start)
        begin
            ptr_next       = head_reg;
            left_next      = count_reg;
            cmp_valid_next = 1'b0;
            hit_next       = 1'b0;
        end
        if (cmd.scan_step)
        begin
            // read issued this cycle is compared next cycle
            cmp_valid_next = (left_reg != '0);
            if (left_reg != '0)
            begin
                ptr_next  = next_slot(ptr_reg);
                left_next = left_reg - 1'b1;
            end
            if (cmp_valid_reg && (rd_data.id == req_reg.id))
            begin
                hit_next = 1'b1;
            end
        end
        if (cmd.enq_write)
        begin
            tail_next    = next_slot(tail_reg);
            count_next   = count_reg + 1'b1;
            counter_next = counter_reg + 1'b1;
        end
        if (cmd.deq_pop)
        begin
            head_next  = next_slot(head_reg);
            count_next = count_reg - 1'b1;
        end
        if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            counter_reg   <= '0;
            ptr_reg       <= '0;
            left_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            counter_reg   <= counter_next;
            ptr_reg       <= ptr_next;
            left_reg      <= left_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg    <= op_t'(op);
            req_reg.id    <= req_id;
            req_reg.tier  <= tier;
            req_reg.size  <= alloc_size;
            req_reg.stamp <= time_stamp;
            req_reg.number <= '0;
        end

        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
            res_reg        <= '0;
        end
        else if (cmd.enq_write)
        begin
            res_status_reg <= ST_OK;
            res_reg        <= enq_res;
        end
        else if (cmd.deq_pop)
        begin
            res_status_reg <= ST_OK;
            res_reg        <= rd_data;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_reg        <= res_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign sts.op        = req_op_reg;
    assign sts.id_zero   = (req_reg.id == '0);
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CNT_W'(DEPTH));
    assign sts.scan_done = (left_reg == '0) && !cmp_valid_reg;
    assign sts.hit       = hit_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign request_number = out_reg.number;
    assign out_req_id     = out_reg.id;
    assign out_tier       = out_reg.tier;
    assign out_alloc_size = out_reg.size;
    assign out_time_stamp = out_reg.stamp;
    assign entry_count    = out_count_reg;

endmodule

// File: hw/rtl/drf_ctrl.sv
// drf_ctrl: sequencing state machine of the request queue.
// Uses drf_pkg command/status bundles; drives drf_datapath.
module drf_ctrl
    import drf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  drf_sts_t sts,
    output drf_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DEQ_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op)
                    OP_ENQ:
                    begin
                        if (sts.id_zero)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_INVALID;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_NOT_FOUND;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            cmd.deq_read = 1'b1;
                            state_next   = S_DEQ_WAIT;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear      = 1'b1;
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_OK;
                        state_next     = S_FINISH;
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_INVALID;
                        state_next     = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    // duplicate check wins over full
                    if (sts.hit)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_EXISTS;
                    end
                    else if (sts.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_FULL;
                    end
                    else
                    begin
                        cmd.enq_write = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DEQ_WAIT:
            begin
                cmd.deq_pop = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/dedup_request_fifo.sv
// dedup_request_fifo: FIFO of placement requests that refuses null and duplicate ids.
// Top level; instantiates drf_ctrl and drf_datapath, uses drf_pkg.
//
// Input channel (in_valid/in_ready) carries one operation per transfer:
// enqueue, dequeue or clear, with object id, tier, size and time stamp.
// Output channel (out_valid/out_ready) returns exactly one result per
// operation: status, request number, dequeued entry fields and the entry
// count after the operation.
// One operation is in flight at a time. An enqueue of a nonzero id
// compares the id against every waiting entry, one RAM read per cycle.
// The result sits in an output register; the next operation is accepted
// while it waits, and a new result waits in the datapath until the output
// register frees up. A stalled receiver thus blocks after one more input.
// Reset empties the queue and zeroes the request counter; no RAM clearing.
module dedup_request_fifo
    import drf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            op,
    input  logic [ID_W-1:0]            req_id,
    input  logic [TIER_W-1:0]          tier,
    input  logic [SIZE_W-1:0]          alloc_size,
    input  logic [STAMP_W-1:0]         time_stamp,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic [NUM_W-1:0]           request_number,
    output logic [ID_W-1:0]            out_req_id,
    output logic [TIER_W-1:0]          out_tier,
    output logic [SIZE_W-1:0]          out_alloc_size,
    output logic [STAMP_W-1:0]         out_time_stamp,
    output logic [$clog2(DEPTH+1)-1:0] entry_count
);

    drf_cmd_t cmd;
    drf_sts_t sts;

    drf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    drf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .op             (op),
        .req_id         (req_id),
        .tier           (tier),
        .alloc_size     (alloc_size),
        .time_stamp     (time_stamp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .request_number (request_number),
        .out_req_id     (out_req_id),
        .out_tier       (out_tier),
        .out_alloc_size (out_alloc_size),
        .out_time_stamp (out_time_stamp),
        .entry_count    (entry_count)
    );

endmodule

// File: sim/tb.sv
// tb: self-checking bench for dedup_request_fifo, a request queue that refuses null and
// duplicate ids. Needs drf_pkg and the RTL; a shadow queue predicts every result, and
// randomized valid/ready gaps exercise both channels.
module tb;
    import drf_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int CNT_W        = $clog2(QDEPTH + 1);
    localparam int RANDOM_ITEMS = 1925;
    localparam int BLOCK        = 25;
    localparam int WATCHDOG     = 1000;
    localparam int TAIL_CYCLES  = 40;
    localparam int MAX_ROWS     = 64;
    localparam int PEND_DEPTH   = 8;
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;
    localparam logic [ID_W-1:0] ALL_ONES = '1;
    localparam logic [ID_W-1:0] FILL_BASE = 64'h0123_4567_89AB_CDEF;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ID_W-1:0]    id;
        logic [TIER_W-1:0]  tier;
        logic [SIZE_W-1:0]  size;
        logic [STAMP_W-1:0] stamp;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUM_W-1:0]    number;
        logic [ID_W-1:0]     id;
        logic [TIER_W-1:0]   tier;
        logic [SIZE_W-1:0]   size;
        logic [STAMP_W-1:0]  stamp;
        logic [CNT_W-1:0]    count;
    } reply_t;

    typedef struct {
        request_t rq;
        bit       typed;
        reply_t   want;
    } table_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     op = OP_ENQ;
    logic [ID_W-1:0]     req_id = '0;
    logic [TIER_W-1:0]   tier = '0;
    logic [SIZE_W-1:0]   alloc_size = '0;
    logic [STAMP_W-1:0]  time_stamp = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    request_number;
    logic [ID_W-1:0]     out_req_id;
    logic [TIER_W-1:0]   out_tier;
    logic [SIZE_W-1:0]   out_alloc_size;
    logic [STAMP_W-1:0]  out_time_stamp;
    logic [CNT_W-1:0]    entry_count;

    // shadow copy of the queue
    logic [ID_W-1:0]    shadow_ids[QDEPTH];
    logic [TIER_W-1:0]  shadow_tiers[QDEPTH];
    logic [SIZE_W-1:0]  shadow_sizes[QDEPTH];
    logic [STAMP_W-1:0] shadow_stamps[QDEPTH];
    logic [NUM_W-1:0]   shadow_numbers[QDEPTH];
    int unsigned        shadow_head = 0;
    int unsigned        shadow_tail = 0;
    int unsigned        shadow_count = 0;
    logic [NUM_W-1:0]   shadow_number = '0;

    // expected results in transfer order, ring indexed by running counts
    reply_t        pending_results[PEND_DEPTH];
    int            pend_wr = 0;
    int            pend_rd = 0;
    table_row_t    directed_rows[MAX_ROWS];
    int            row_total = 0;
    logic [ID_W-1:0] id_pool[8];
    bit            no_idle = 1'b0;
    int            fail_count = 0;
    int            results_seen = 0;
    int            idle_cycles = 0;
    int            op_tally[4];
    int            status_tally[5];

    always #4 clk = ~clk;

    dedup_request_fifo #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .req_id         (req_id),
        .tier           (tier),
        .alloc_size     (alloc_size),
        .time_stamp     (time_stamp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .request_number (request_number),
        .out_req_id     (out_req_id),
        .out_tier       (out_tier),
        .out_alloc_size (out_alloc_size),
        .out_time_stamp (out_time_stamp),
        .entry_count    (entry_count)
    );

    function automatic request_t make_request(logic [OP_W-1:0] o, logic [ID_W-1:0] id,
                                              logic [TIER_W-1:0] t, logic [SIZE_W-1:0] sz,
                                              logic [STAMP_W-1:0] ts);
        request_t rq;
        rq.op    = o;
        rq.id    = id;
        rq.tier  = t;
        rq.size  = sz;
        rq.stamp = ts;
        return rq;
    endfunction

    function automatic reply_t make_reply(logic [STATUS_W-1:0] st, logic [NUM_W-1:0] num,
                                          logic [ID_W-1:0] id, logic [TIER_W-1:0] t,
                                          logic [SIZE_W-1:0] sz, logic [STAMP_W-1:0] ts,
                                          logic [CNT_W-1:0] cnt);
        reply_t rp;
        rp.status = st;
        rp.number = num;
        rp.id     = id;
        rp.tier   = t;
        rp.size   = sz;
        rp.stamp  = ts;
        rp.count  = cnt;
        return rp;
    endfunction

    function automatic void add_row(request_t rq, bit typed, reply_t want);
        table_row_t row;
        row.rq    = rq;
        row.typed = typed;
        row.want  = want;
        directed_rows[row_total] = row;
        row_total++;
    endfunction

    // Applies one operation to the shadow queue and returns the result it should give.
    function automatic reply_t predict_queue_op(request_t rq);
        reply_t      rp;
        int unsigned slot;
        int unsigned n;
        bit          dup;
        rp = '0;
        case (rq.op)
            OP_ENQ:
            begin
                dup = 1'b0;
                slot = shadow_head;
                for (n = 0; n < shadow_count; n++)
                begin
                    if (shadow_ids[slot] == rq.id)
                        dup = 1'b1;
                    slot = (slot + 1) % QDEPTH;
                end
                if (rq.id == '0)
                    rp.status = ST_INVALID;
                else if (dup)
                    rp.status = ST_EXISTS;
                else if (shadow_count >= QDEPTH)
                    rp.status = ST_FULL;
                else
                begin
                    shadow_number = shadow_number + 1'b1;
                    shadow_ids[shadow_tail]     = rq.id;
                    shadow_tiers[shadow_tail]   = rq.tier;
                    shadow_sizes[shadow_tail]   = rq.size;
                    shadow_stamps[shadow_tail]  = rq.stamp;
                    shadow_numbers[shadow_tail] = shadow_number;
                    shadow_tail = (shadow_tail + 1) % QDEPTH;
                    shadow_count++;
                    rp.status = ST_OK;
                    rp.number = shadow_number;
                end
            end
            OP_DEQ:
            begin
                if (shadow_count == 0)
                    rp.status = ST_NOT_FOUND;
                else
                begin
                    rp.status = ST_OK;
                    rp.number = shadow_numbers[shadow_head];
                    rp.id     = shadow_ids[shadow_head];
                    rp.tier   = shadow_tiers[shadow_head];
                    rp.size   = shadow_sizes[shadow_head];
                    rp.stamp  = shadow_stamps[shadow_head];
                    shadow_head = (shadow_head + 1) % QDEPTH;
                    shadow_count--;
                end
            end
            OP_CLEAR:
            begin
                // counter survives a clear
                shadow_head  = 0;
                shadow_tail  = 0;
                shadow_count = 0;
                rp.status    = ST_OK;
            end
            default:
                rp.status = ST_INVALID;
        endcase
        rp.count = CNT_W'(shadow_count);
        return rp;
    endfunction

    // Enqueue ids mix null, currently waiting, recycled and fresh values so that
    // duplicates and a full queue come up often.
    function automatic request_t random_request(int enq_pct);
        request_t rq;
        int       pick;
        rq.id    = {$urandom, $urandom};
        rq.tier  = TIER_W'($urandom);
        rq.size  = {$urandom, $urandom};
        rq.stamp = {$urandom, $urandom};
        if ($urandom_range(0, 99) < enq_pct)
        begin
            rq.op = OP_ENQ;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                rq.id = '0;
            else if (pick < 30 && shadow_count > 0)
                rq.id = shadow_ids[(shadow_head + $urandom_range(0, shadow_count - 1)) % QDEPTH];
            else if (pick < 50)
                rq.id = id_pool[$urandom_range(0, 7)];
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
                rq.op = OP_DEQ;
            else if (pick < 95)
                rq.op = OP_CLEAR;
            else
                rq.op = OP_UNDEF;
        end
        return rq;
    endfunction

    task automatic send_request(input request_t rq, input bit typed, input reply_t want);
        int     gap;
        reply_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        op         <= rq.op;
        req_id     <= rq.id;
        tier       <= rq.tier;
        alloc_size <= rq.size;
        time_stamp <= rq.stamp;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_queue_op(rq);
        pending_results[pend_wr % PEND_DEPTH] = typed ? want : predicted;
        pend_wr++;
        op_tally[rq.op]++;
        status_tally[predicted.status]++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = make_reply(status, request_number, out_req_id, out_tier,
                             out_alloc_size, out_time_stamp, entry_count);
            results_seen++;
            if (pend_wr == pend_rd)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d arrived with nothing expected: st=%0d num=%0d cnt=%0d",
                             results_seen, got.status, got.number, got.count);
            end
            else
            begin
                want = pending_results[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("result %0d mismatch", results_seen);
                        $display("  expected st=%0d num=%0d id=%h tier=%0d size=%h stamp=%h cnt=%0d",
                                 want.status, want.number, want.id, want.tier, want.size,
                                 want.stamp, want.count);
                        $display("  actual   st=%0d num=%0d id=%h tier=%0d size=%h stamp=%h cnt=%0d",
                                 got.status, got.number, got.id, got.tier, got.size,
                                 got.stamp, got.count);
                    end
                end
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG)
        begin
            $display("timeout after %0d cycles without a transfer", WATCHDOG);
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result receiver
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // request sender
    initial
    begin
        int i;
        int blk;
        int k;
        int enq_pct;
        for (i = 0; i < 8; i++)
            id_pool[i] = {$urandom, $urandom};
        for (i = 0; i < 4; i++)
            op_tally[i] = 0;
        for (i = 0; i < 5; i++)
            status_tally[i] = 0;

        add_row(make_request(OP_DEQ, 0, 0, 0, 0), 1'b1,
                make_reply(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        add_row(make_request(OP_ENQ, 0, 2, 64'h1234, 64'h5678), 1'b1,
                make_reply(ST_INVALID, 0, 0, 0, 0, 0, 0));
        add_row(make_request(OP_UNDEF, 5, 1, ALL_ONES, ALL_ONES), 1'b1,
                make_reply(ST_INVALID, 0, 0, 0, 0, 0, 0));
        add_row(make_request(OP_ENQ, ALL_ONES, 3, ALL_ONES, ALL_ONES), 1'b1,
                make_reply(ST_OK, 1, 0, 0, 0, 0, 1));
        add_row(make_request(OP_ENQ, ALL_ONES, 0, 0, 0), 1'b1,
                make_reply(ST_EXISTS, 0, 0, 0, 0, 0, 1));
        add_row(make_request(OP_ENQ, 1, 0, 0, 0), 1'b1,
                make_reply(ST_OK, 2, 0, 0, 0, 0, 2));
        add_row(make_request(OP_DEQ, 0, 0, 0, 0), 1'b1,
                make_reply(ST_OK, 1, ALL_ONES, 3, ALL_ONES, ALL_ONES, 1));
        add_row(make_request(OP_CLEAR, ALL_ONES, 3, 0, 0), 1'b1,
                make_reply(ST_OK, 0, 0, 0, 0, 0, 0));
        add_row(make_request(OP_DEQ, 0, 0, 0, 0), 1'b1,
                make_reply(ST_NOT_FOUND, 0, 0, 0, 0, 0, 0));
        // fill to capacity, then a duplicate and a fresh id against the full queue
        for (i = 0; i < QDEPTH; i++)
            add_row(make_request(OP_ENQ, FILL_BASE ^ (64'(i) << 56), TIER_W'(i),
                                 {$urandom, $urandom}, {$urandom, $urandom}), 1'b0, '0);
        add_row(make_request(OP_ENQ, FILL_BASE ^ (64'(5) << 56), 2, 0, 0), 1'b1,
                make_reply(ST_EXISTS, 0, 0, 0, 0, 0, CNT_W'(QDEPTH)));
        add_row(make_request(OP_ENQ, 64'h8000_0000_0000_0000, 1, 0, 0), 1'b1,
                make_reply(ST_FULL, 0, 0, 0, 0, 0, CNT_W'(QDEPTH)));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < row_total; i++)
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

        for (blk = 0; blk < RANDOM_ITEMS / BLOCK; blk++)
        begin
            enq_pct = 35 + 20 * $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 3) == 0);
            for (k = 0; k < BLOCK; k++)
                send_request(random_request(enq_pct), 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d operations: %0d enqueue, %0d dequeue, %0d clear, %0d undefined",
                 op_tally[OP_ENQ] + op_tally[OP_DEQ] + op_tally[OP_CLEAR] + op_tally[OP_UNDEF],
                 op_tally[OP_ENQ], op_tally[OP_DEQ], op_tally[OP_CLEAR], op_tally[OP_UNDEF]);
        $display("outcomes: %0d ok, %0d invalid, %0d duplicate, %0d empty, %0d full; %0d failures",
                 status_tally[ST_OK], status_tally[ST_INVALID], status_tally[ST_EXISTS],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FULL], fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/drf_pkg.sv
hw/rtl/drf_ram.sv
hw/rtl/drf_datapath.sv
hw/rtl/drf_ctrl.sv
hw/rtl/dedup_request_fifo.sv
sim/tb.sv
